// ----- hw/rtl/u8ls_pkg.sv -----
package u8ls_pkg;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_LINE_END = 2'd1;
    localparam logic [1:0] KIND_DROPPED  = 2'd2;

    // line break types
    localparam logic [1:0] BRK_NONE = 2'd0;
    localparam logic [1:0] BRK_LF   = 2'd1;
    localparam logic [1:0] BRK_CR   = 2'd2;
    localparam logic [1:0] BRK_CRLF = 2'd3;

    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BOM_BYTE0  = 8'hef;
    localparam logic [7:0] BOM_BYTE1  = 8'hbb;
    localparam logic [7:0] BOM_BYTE2  = 8'hbf;

    localparam logic [15:0] MAX_LINE_RESET = 16'hffff;

    // configuration register indexes
    localparam logic REG_MAX_LINE_BYTES = 1'b0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [30:0] code_point;
        logic [2:0]  seq_len;
        logic [1:0]  break_type;
        logic        last;
    } t_out_item;

    // one queue entry holds every result of one request
    typedef struct packed {
        logic      two;
        t_out_item r0;
        t_out_item r1;
    } t_q_entry;

    typedef struct packed {
        logic     push;
        t_q_entry entry;
    } t_q_push;

    typedef struct packed {
        logic     full;
        logic     empty;
        t_q_entry head;
    } t_q_status;

    function automatic t_out_item mk_res(logic [1:0] kind, logic [30:0] cp,
                                         logic [2:0] len, logic [1:0] brk);
        t_out_item r;
        r.kind       = kind;
        r.code_point = cp;
        r.seq_len    = len;
        r.break_type = brk;
        r.last       = 1'b0;
        return r;
    endfunction

    // nonempty line that the next character would push past the limit
    function automatic logic need_split(logic [15:0] lbc, logic [2:0] len,
                                        logic [15:0] max_bytes);
        logic [16:0] sum;
        sum = {1'b0, lbc} + {14'd0, len};
        return (lbc != 16'd0) && (sum > {1'b0, max_bytes});
    endfunction

endpackage

// ----- hw/rtl/utf8_decoder_line_splitter_top.sv -----
// Lenient UTF-8 decoder and line splitter. Each request carries one stream
// byte or an end-of-stream marker; results (a character with its code point
// and length, a line end with its break type, or a dropped incomplete
// sequence) leave one per clock while taken, with last set on the final result
// of each request. A request yields zero, one or two results, so a byte stream
// runs at one byte per clock as long as results are taken every clock; a
// request with two results holds the output until both have left. The front
// stage decodes and classifies combinationally and writes all results of a
// request into a four-entry queue; the back stage serializes them into a
// registered output, so input and output stall independently. A leading
// EF BB BF mark is dropped, CRLF is recognized across any gap between bytes,
// and end of stream flushes a pending CR, an unfinished sequence and an open
// line, then restarts for a new stream. max_line_bytes sits at address 0 of
// the APB port and should only be written while the block is idle.
module utf8_decoder_line_splitter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,

    // byte requests
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  u8ls_pkg::t_in_item  i_in_item,

    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output u8ls_pkg::t_out_item o_out_item,

    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import u8ls_pkg::*;

    logic [15:0] r_max_line_bytes;
    t_q_push     q_push;
    t_q_status   q_status;
    logic        q_pop;
    logic        reg_hit;

    // register file: one word, decode the word index from the byte address
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_MAX_LINE_BYTES);
    assign prdata  = reg_hit ? {16'd0, r_max_line_bytes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_line_bytes <= MAX_LINE_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_max_line_bytes <= pwdata[15:0];
        end
    end

    // decode and classify each request
    u8ls_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_item        (i_in_item),
        .i_max_line_bytes (r_max_line_bytes),
        .i_q_status       (q_status),
        .o_q_push         (q_push)
    );

    // decouple decode from result delivery
    u8ls_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_push   (q_push),
        .i_pop      (q_pop),
        .o_q_status (q_status)
    );

    // serialize queued results onto the output register
    u8ls_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (q_status),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- hw/rtl/u8ls_front.sv -----
module u8ls_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  u8ls_pkg::t_in_item  i_in_item,
    input  logic [15:0]         i_max_line_bytes,
    input  u8ls_pkg::t_q_status i_q_status,
    output u8ls_pkg::t_q_push   o_q_push
);
    import u8ls_pkg::*;

    logic [30:0] r_accum,  n_accum;
    logic [2:0]  r_remain, n_remain;
    logic [2:0]  r_cur,    n_cur;
    logic [15:0] r_lbc,    n_lbc;
    logic        r_cr,     n_cr;
    logic        r_start,  n_start;
    logic        r_bom,    n_bom;

    t_out_item   res [2];
    logic [1:0]  cnt;
    logic        accept;

    assign o_in_ready = !i_q_status.full;
    assign accept     = i_in_valid && !i_q_status.full;

    always_comb begin
        logic [7:0]  b;
        logic [2:0]  len;
        logic [30:0] payload;
        logic [2:0]  pos;
        logic [7:0]  want;
        b        = i_in_item.data_byte;
        len      = 3'd1;
        payload  = 31'd0;
        pos      = r_cur - r_remain;
        want     = (pos == 3'd1) ? BOM_BYTE1 : BOM_BYTE2;
        n_accum  = r_accum;
        n_remain = r_remain;
        n_cur    = r_cur;
        n_lbc    = r_lbc;
        n_cr     = r_cr;
        n_start  = r_start;
        n_bom    = r_bom;
        res[0]   = mk_res(KIND_CHAR, 31'd0, 3'd0, BRK_NONE);
        res[1]   = res[0];
        cnt      = 2'd0;

        if (i_in_item.end_of_stream) begin
            // flush whatever is pending, then restart the stream state
            if (r_cr) begin
                res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_CR);
                cnt = cnt + 2'd1;
            end else begin
                if (r_remain != 3'd0) begin
                    res[cnt[0]] = mk_res(KIND_DROPPED, 31'd0, pos, BRK_NONE);
                    cnt = cnt + 2'd1;
                end
                if (r_lbc != 16'd0) begin
                    res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_NONE);
                    cnt = cnt + 2'd1;
                end
            end
            n_accum  = 31'd0;
            n_remain = 3'd0;
            n_cur    = 3'd0;
            n_lbc    = 16'd0;
            n_cr     = 1'b0;
            n_start  = 1'b1;
            n_bom    = 1'b1;
        end else if (r_remain != 3'd0) begin
            // continuation: no check, take the low six bits
            if (r_bom && b != want) begin
                n_bom = 1'b0;
            end
            n_accum  = {r_accum[24:0], b[5:0]};
            n_remain = r_remain - 3'd1;
            if (n_remain == 3'd0) begin
                if (n_bom) begin
                    n_bom = 1'b0;
                end else begin
                    if (need_split(n_lbc, r_cur, i_max_line_bytes)) begin
                        res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_NONE);
                        cnt = cnt + 2'd1;
                        n_lbc = 16'd0;
                    end
                    res[cnt[0]] = mk_res(KIND_CHAR, n_accum, r_cur, BRK_NONE);
                    cnt = cnt + 2'd1;
                    n_lbc = n_lbc + {13'd0, r_cur};
                end
            end
        end else begin
            n_start = 1'b0;
            if (r_cr) begin
                n_cr = 1'b0;
                if (b == BYTE_LF) begin
                    res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_CRLF);
                    cnt = cnt + 2'd1;
                end else begin
                    res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_CR);
                    cnt = cnt + 2'd1;
                end
            end
            if (!(r_cr && b == BYTE_LF)) begin
                if (b[7] == 1'b0) begin
                    len = 3'd1; payload = {23'd0, b};
                end else if (b[7:5] == 3'b110) begin
                    len = 3'd2; payload = {26'd0, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    len = 3'd3; payload = {27'd0, b[3:0]};
                end else if (b[7:3] == 5'b11110) begin
                    len = 3'd4; payload = {28'd0, b[2:0]};
                end else if (b[7:2] == 6'b111110) begin
                    len = 3'd5; payload = {29'd0, b[1:0]};
                end else begin
                    len = 3'd6; payload = {30'd0, b[0]};
                end
                n_bom = r_start && (b == BOM_BYTE0);
                if (len == 3'd1) begin
                    if (need_split(n_lbc, 3'd1, i_max_line_bytes)) begin
                        res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_NONE);
                        cnt = cnt + 2'd1;
                        n_lbc = 16'd0;
                    end
                    if (b == BYTE_LF) begin
                        res[cnt[0]] = mk_res(KIND_LINE_END, 31'd0, 3'd0, BRK_LF);
                        cnt = cnt + 2'd1;
                        n_lbc = 16'd0;
                    end else if (b == BYTE_CR) begin
                        n_lbc = 16'd0;
                        n_cr  = 1'b1;
                    end else begin
                        res[cnt[0]] = mk_res(KIND_CHAR, payload, 3'd1, BRK_NONE);
                        cnt = cnt + 2'd1;
                        n_lbc = n_lbc + 16'd1;
                    end
                end else begin
                    n_accum  = payload;
                    n_cur    = len;
                    n_remain = len - 3'd1;
                end
            end
        end

        if (cnt == 2'd1) begin
            res[0].last = 1'b1;
        end
        if (cnt == 2'd2) begin
            res[1].last = 1'b1;
        end
    end

    assign o_q_push.push     = accept && (cnt != 2'd0);
    assign o_q_push.entry.two = (cnt == 2'd2);
    assign o_q_push.entry.r0 = res[0];
    assign o_q_push.entry.r1 = res[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum  <= '0;
            r_remain <= '0;
            r_cur    <= '0;
            r_lbc    <= '0;
            r_cr     <= 1'b0;
            r_start  <= 1'b1;
            r_bom    <= 1'b1;
        end else if (accept) begin
            r_accum  <= n_accum;
            r_remain <= n_remain;
            r_cur    <= n_cur;
            r_lbc    <= n_lbc;
            r_cr     <= n_cr;
            r_start  <= n_start;
            r_bom    <= n_bom;
        end
    end

    a_remain_below_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_remain != 3'd0) |-> (r_remain < r_cur && !r_cr))
        else $error("sequence counter out of step with its length");

endmodule

// ----- hw/rtl/u8ls_queue.sv -----
module u8ls_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8ls_pkg::t_q_push   i_q_push,
    input  logic                i_pop,
    output u8ls_pkg::t_q_status o_q_status
);
    import u8ls_pkg::*;

    t_q_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]     r_wptr, r_rptr;
    logic [QCOUNT_W-1:0]   r_count;
    logic                  do_push, do_pop;

    assign o_q_status.full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_q_status.empty = (r_count == '0);
    assign o_q_status.head  = r_mem[r_rptr];

    assign do_push = i_q_push.push && !o_q_status.full;
    assign do_pop  = i_pop && !o_q_status.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_q_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCOUNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCOUNT_W'(1);
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_push.push |-> !o_q_status.full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_q_status.empty)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= QCOUNT_W'(QDEPTH)) &&
        ((r_count == '0 || r_count == QCOUNT_W'(QDEPTH)) || (r_wptr != r_rptr)))
        else $error("queue occupancy inconsistent with pointers");

endmodule

// ----- hw/rtl/u8ls_back.sv -----
module u8ls_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  u8ls_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output u8ls_pkg::t_out_item o_out_item
);
    import u8ls_pkg::*;

    t_out_item r_out;
    t_out_item r_hold;
    logic      r_out_valid;
    logic      r_hold_valid;
    logic      load;

    assign load  = !r_out_valid || i_out_ready;
    assign o_pop = load && !r_hold_valid && !i_q_status.empty;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_hold_valid) begin
                r_out <= r_hold;
            end else begin
                r_out  <= i_q_status.head.r0;
                r_hold <= i_q_status.head.r1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else if (load) begin
            if (r_hold_valid) begin
                r_out_valid  <= 1'b1;
                r_hold_valid <= 1'b0;
            end else begin
                r_out_valid  <= !i_q_status.empty;
                r_hold_valid <= !i_q_status.empty && i_q_status.head.two;
            end
        end
    end

    a_hold_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hold_valid |-> (r_out_valid && !r_out.last))
        else $error("second result held without a first one in front");

endmodule
